FILE: src/wfmw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfmw_pkg: shared definitions for the wall-following maze walk
// Sizes, result status codes, register indexes and the microcode ROM that
// sequences the walk, the path bookkeeping and the path read-out.
// ----------------------------------------------------------------------------
package wfmw_pkg;

  // Grid and store sizes.
  localparam int MaxGrid  = 8;
  localparam int MaxCells = MaxGrid * MaxGrid;
  localparam int CellW    = $clog2(MaxCells);
  localparam int LenW     = CellW + 1;
  localparam int StepW    = 12;
  localparam int PcW      = 5;

  typedef logic [PcW-1:0] pc_t;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t StGoal     = 2'd0;
  localparam status_t StLimit    = 2'd1;
  localparam status_t StBoxed    = 2'd2;
  localparam status_t StBadStart = 2'd3;

  // Headings.
  localparam logic [1:0] HeadUp    = 2'd0;
  localparam logic [1:0] HeadRight = 2'd1;
  localparam logic [1:0] HeadDown  = 2'd2;
  localparam logic [1:0] HeadLeft  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] RegWallMap   = 2'd0;
  localparam logic [1:0] RegGridSize  = 2'd1;
  localparam logic [1:0] RegLeftHand  = 2'd2;
  localparam logic [1:0] RegStepLimit = 2'd3;

  // Datapath actions of one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RD_PATH,
    OP_UPDATE,
    OP_TURN_HAND,
    OP_TURN_BACK,
    OP_MOVE,
    OP_STAT_LIMIT,
    OP_STAT_BOXED,
    OP_SHOW,
    OP_SHOW_BAD
  } op_t;

  // Jump conditions of one control word.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_BAD_START,
    C_AT_GOAL,
    C_AT_LIMIT,
    C_OPEN,
    C_MORE_TRIES,
    C_OUT_BUSY,
    C_MORE_CELLS
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Program step addresses.
  localparam pc_t PcWait      = 5'd0;
  localparam pc_t PcCheckBad  = 5'd1;
  localparam pc_t PcRdPos     = 5'd2;
  localparam pc_t PcRdPath    = 5'd3;
  localparam pc_t PcUpdate    = 5'd4;
  localparam pc_t PcGoal      = 5'd5;
  localparam pc_t PcLimit     = 5'd6;
  localparam pc_t PcTurnHand  = 5'd7;
  localparam pc_t PcTry       = 5'd8;
  localparam pc_t PcTurnBack  = 5'd9;
  localparam pc_t PcBoxed     = 5'd10;
  localparam pc_t PcMove      = 5'd11;
  localparam pc_t PcStatLimit = 5'd12;
  localparam pc_t PcRdEmit    = 5'd13;
  localparam pc_t PcShow      = 5'd14;
  localparam pc_t PcNextCell  = 5'd15;
  localparam pc_t PcDone      = 5'd16;
  localparam pc_t PcShowBad   = 5'd17;
  localparam pc_t PcBadDone   = 5'd18;

  // Microcode ROM. A taken jump goes to target, otherwise the next step runs.
  function automatic uword_t ucode_rom(pc_t pc);
    uword_t w;
    unique case (pc)
      PcWait:      w = '{OP_LOAD,       C_NO_INPUT,   PcWait};
      PcCheckBad:  w = '{OP_NOP,        C_BAD_START,  PcShowBad};
      PcRdPos:     w = '{OP_NOP,        C_NEVER,      PcWait};
      PcRdPath:    w = '{OP_RD_PATH,    C_NEVER,      PcWait};
      PcUpdate:    w = '{OP_UPDATE,     C_NEVER,      PcWait};
      PcGoal:      w = '{OP_NOP,        C_AT_GOAL,    PcRdEmit};
      PcLimit:     w = '{OP_NOP,        C_AT_LIMIT,   PcStatLimit};
      PcTurnHand:  w = '{OP_TURN_HAND,  C_NEVER,      PcWait};
      PcTry:       w = '{OP_NOP,        C_OPEN,       PcMove};
      PcTurnBack:  w = '{OP_TURN_BACK,  C_MORE_TRIES, PcTry};
      PcBoxed:     w = '{OP_STAT_BOXED, C_ALWAYS,     PcRdEmit};
      PcMove:      w = '{OP_MOVE,       C_ALWAYS,     PcRdPos};
      PcStatLimit: w = '{OP_STAT_LIMIT, C_NEVER,      PcWait};
      PcRdEmit:    w = '{OP_NOP,        C_NEVER,      PcWait};
      PcShow:      w = '{OP_SHOW,       C_OUT_BUSY,   PcShow};
      PcNextCell:  w = '{OP_NOP,        C_MORE_CELLS, PcRdEmit};
      PcDone:      w = '{OP_NOP,        C_ALWAYS,     PcWait};
      PcShowBad:   w = '{OP_SHOW_BAD,   C_OUT_BUSY,   PcShowBad};
      PcBadDone:   w = '{OP_NOP,        C_ALWAYS,     PcWait};
      default:     w = '{OP_NOP,        C_ALWAYS,     PcWait};
    endcase
    return w;
  endfunction

endpackage

FILE: src/wfmw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wfmw_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. A read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module wfmw_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem_r [Depth];
  logic [Width-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: src/wall_follower_maze_walk_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_follower_maze_walk_top: wall-following maze walk with loop erasure
// Walks a configured grid from a start cell by the right- or left-hand rule
// and streams out the loop-erased path, one cell per word.
// ----------------------------------------------------------------------------
// The block takes one start word at a time and accepts the next only after
// the current walk has been handed to the output register. Each move runs
// through the microcode loop that checks goal and step limit, tries
// headings, moves and updates the path stores over their registered read
// ports. The path cells are then read out one at a time, held while the
// output side stalls. The result word holds the raw move count and the
// status on every path cell, with tlast on the final one.
module wall_follower_maze_walk_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // start_col[2:0], start_row[5:3], start_heading[7:6]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // cell_col[2:0], cell_row[5:3], walk_steps[17:6], zeros
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast,  // last_cell
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CellW = wfmw_pkg::CellW;
  localparam int LenW  = wfmw_pkg::LenW;
  localparam int StepW = wfmw_pkg::StepW;

  // Configuration registers.
  logic [63:0]      wall_map_r;
  logic [3:0]       grid_size_r;
  logic             left_hand_r;
  logic [StepW-1:0] step_limit_r;

  // Sequencer and walk state.
  wfmw_pkg::pc_t     pc_r, pc_nxt;
  wfmw_pkg::uword_t  uw;
  logic [2:0]        cur_col_r, cur_col_nxt;
  logic [2:0]        cur_row_r, cur_row_nxt;
  logic [1:0]        heading_r, heading_nxt;
  logic [1:0]        tries_r, tries_nxt;
  logic [StepW-1:0]  move_count_r, move_count_nxt;
  logic [LenW-1:0]   len_r, len_nxt;
  logic [LenW-1:0]   k_r, k_nxt;
  wfmw_pkg::status_t status_r, status_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        out_col_r, out_col_nxt;
  logic [2:0]        out_row_r, out_row_nxt;
  logic [StepW-1:0]  out_steps_r, out_steps_nxt;
  wfmw_pkg::status_t out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  // Datapath signals.
  logic [3:0]       n_eff;
  logic [2:0]       goal_idx;
  logic [CellW-1:0] cur_cell;
  logic [3:0]       nc, nr;
  logic             off_side;
  logic [6:0]       wall_idx;
  logic             open_ahead;
  logic             hit;
  logic             out_free;
  logic             cond_true;
  logic             cfg_wr;
  logic [LenW-1:0]  k_inc;

  // Path stores.
  logic             pos_we;
  logic [CellW-1:0] pos_rd;
  logic             path_we;
  logic [CellW-1:0] path_raddr;
  logic [CellW-1:0] path_rd;

  // Configuration write and read.
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_map_r   <= '0;
      grid_size_r  <= 4'd3;
      left_hand_r  <= 1'b0;
      step_limit_r <= 12'd1024;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        wfmw_pkg::RegWallMap:   wall_map_r   <= cfg_pwdata;
        wfmw_pkg::RegGridSize:  grid_size_r  <= cfg_pwdata[3:0];
        wfmw_pkg::RegLeftHand:  left_hand_r  <= cfg_pwdata[0];
        wfmw_pkg::RegStepLimit: step_limit_r <= cfg_pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:3])
      wfmw_pkg::RegWallMap:   cfg_prdata = wall_map_r;
      wfmw_pkg::RegGridSize:  cfg_prdata = {60'd0, grid_size_r};
      wfmw_pkg::RegLeftHand:  cfg_prdata = {63'd0, left_hand_r};
      wfmw_pkg::RegStepLimit: cfg_prdata = {52'd0, step_limit_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // Grid side clamped to the supported range.
  always_comb begin
    if (grid_size_r < 4'd2) begin
      n_eff = 4'd2;
    end else if (grid_size_r > 4'(wfmw_pkg::MaxGrid)) begin
      n_eff = 4'(wfmw_pkg::MaxGrid);
    end else begin
      n_eff = grid_size_r;
    end
  end

  assign goal_idx = 3'(n_eff - 4'd1);
  assign cur_cell = {cur_row_r, cur_col_r};

  // Neighbor in the current heading and whether it can be entered.
  always_comb begin
    nc       = {1'b0, cur_col_r};
    nr       = {1'b0, cur_row_r};
    off_side = 1'b0;
    unique case (heading_r)
      wfmw_pkg::HeadUp: begin
        if (cur_row_r == 3'd0) off_side = 1'b1;
        else nr = nr - 4'd1;
      end
      wfmw_pkg::HeadRight: nc = nc + 4'd1;
      wfmw_pkg::HeadDown:  nr = nr + 4'd1;
      default: begin
        if (cur_col_r == 3'd0) off_side = 1'b1;
        else nc = nc - 4'd1;
      end
    endcase
    wall_idx   = 7'(nr[2:0]) * 7'(n_eff) + 7'(nc[2:0]);
    open_ahead = !off_side && (nc < n_eff) && (nr < n_eff) &&
                 !wall_map_r[wall_idx[CellW-1:0]];
  end

  // A stored position counts only if it lies on the path and points back here.
  always_comb begin
    hit = 1'b0;
    if ({1'b0, pos_rd} < len_r) begin
      if (path_rd == cur_cell) begin
        hit = 1'b1;
      end
    end
  end

  // Microcode fetch and jump condition.
  assign uw       = wfmw_pkg::ucode_rom(pc_r);
  assign out_free = !out_valid_r || out_tready;
  assign k_inc    = LenW'(k_r + 7'd1);

  always_comb begin
    case (uw.cond)
      wfmw_pkg::C_NEVER:      cond_true = 1'b0;
      wfmw_pkg::C_ALWAYS:     cond_true = 1'b1;
      wfmw_pkg::C_NO_INPUT:   cond_true = !in_tvalid;
      wfmw_pkg::C_BAD_START:  cond_true = ({1'b0, cur_col_r} >= n_eff) ||
                                          ({1'b0, cur_row_r} >= n_eff);
      wfmw_pkg::C_AT_GOAL:    cond_true = (cur_col_r == goal_idx) &&
                                          (cur_row_r == goal_idx);
      wfmw_pkg::C_AT_LIMIT:   cond_true = move_count_r >= step_limit_r;
      wfmw_pkg::C_OPEN:       cond_true = open_ahead;
      wfmw_pkg::C_MORE_TRIES: cond_true = tries_r != 2'd3;
      wfmw_pkg::C_OUT_BUSY:   cond_true = !out_free;
      wfmw_pkg::C_MORE_CELLS: cond_true = k_r != len_r;
      default:                cond_true = 1'b0;
    endcase
  end

  assign pc_nxt     = cond_true ? uw.target : wfmw_pkg::pc_t'(pc_r + 5'd1);
  assign in_tready  = (uw.op == wfmw_pkg::OP_LOAD);
  assign path_raddr = (uw.op == wfmw_pkg::OP_RD_PATH) ? pos_rd : k_r[CellW-1:0];

  // Datapath actions selected by the control word.
  always_comb begin
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    heading_nxt    = heading_r;
    tries_nxt      = tries_r;
    move_count_nxt = move_count_r;
    len_nxt        = len_r;
    k_nxt          = k_r;
    status_nxt     = status_r;
    pos_we         = 1'b0;
    path_we        = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    out_steps_nxt  = out_steps_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    unique case (uw.op)
      wfmw_pkg::OP_LOAD: begin
        if (in_tvalid) begin
          cur_col_nxt    = in_tdata[2:0];
          cur_row_nxt    = in_tdata[5:3];
          heading_nxt    = in_tdata[7:6];
          move_count_nxt = '0;
          len_nxt        = '0;
          k_nxt          = '0;
          status_nxt     = wfmw_pkg::StGoal;
        end
      end
      wfmw_pkg::OP_UPDATE: begin
        if (hit) begin
          len_nxt = LenW'({1'b0, pos_rd} + 7'd1);
        end else if (!len_r[LenW-1]) begin
          pos_we  = 1'b1;
          path_we = 1'b1;
          len_nxt = LenW'(len_r + 7'd1);
        end
      end
      wfmw_pkg::OP_TURN_HAND: begin
        heading_nxt = left_hand_r ? 2'(heading_r + 2'd3) : 2'(heading_r + 2'd1);
        tries_nxt   = 2'd0;
      end
      wfmw_pkg::OP_TURN_BACK: begin
        heading_nxt = left_hand_r ? 2'(heading_r + 2'd1) : 2'(heading_r + 2'd3);
        tries_nxt   = 2'(tries_r + 2'd1);
      end
      wfmw_pkg::OP_MOVE: begin
        cur_col_nxt    = nc[2:0];
        cur_row_nxt    = nr[2:0];
        move_count_nxt = StepW'(move_count_r + 12'd1);
      end
      wfmw_pkg::OP_STAT_LIMIT: status_nxt = wfmw_pkg::StLimit;
      wfmw_pkg::OP_STAT_BOXED: status_nxt = wfmw_pkg::StBoxed;
      wfmw_pkg::OP_SHOW: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_col_nxt    = path_rd[2:0];
          out_row_nxt    = path_rd[5:3];
          out_steps_nxt  = move_count_r;
          out_status_nxt = status_r;
          out_last_nxt   = (k_inc == len_r);
          k_nxt          = k_inc;
        end
      end
      wfmw_pkg::OP_SHOW_BAD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_col_nxt    = '0;
          out_row_nxt    = '0;
          out_steps_nxt  = '0;
          out_status_nxt = wfmw_pkg::StBadStart;
          out_last_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= wfmw_pkg::PcWait;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      heading_r    <= wfmw_pkg::HeadUp;
      tries_r      <= '0;
      move_count_r <= '0;
      len_r        <= '0;
      k_r          <= '0;
      status_r     <= wfmw_pkg::StGoal;
      out_valid_r  <= 1'b0;
    end else begin
      pc_r         <= pc_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      heading_r    <= heading_nxt;
      tries_r      <= tries_nxt;
      move_count_r <= move_count_nxt;
      len_r        <= len_nxt;
      k_r          <= k_nxt;
      status_r     <= status_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    out_col_r    <= out_col_nxt;
    out_row_r    <= out_row_nxt;
    out_steps_r  <= out_steps_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Path position of each cell, addressed by the current cell.
  wfmw_ram #(
    .Width (CellW),
    .Depth (wfmw_pkg::MaxCells)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (cur_cell),
    .wdata (len_r[CellW-1:0]),
    .raddr (cur_cell),
    .rdata (pos_rd)
  );

  // Cells of the loop-erased path, stored as row and column.
  wfmw_ram #(
    .Width (CellW),
    .Depth (wfmw_pkg::MaxCells)
  ) u_path_ram (
    .clk   (clk),
    .we    (path_we),
    .waddr (len_r[CellW-1:0]),
    .wdata (cur_cell),
    .raddr (path_raddr),
    .rdata (path_rd)
  );

  // Result stream.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_steps_r, out_row_r, out_col_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // The path never grows past the store depth.
  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LenW'(wfmw_pkg::MaxCells))
    else $error("path length exceeds store depth");

  // An accepted start word always leads to the bad-start check.
  a_load_next : assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (pc_r == wfmw_pkg::PcCheckBad))
    else $error("start word not followed by bad-start check");

  // Re-entering a cell on the path never lengthens it.
  a_erase_shrinks : assert property (@(posedge clk) disable iff (!rst_n)
    (uw.op == wfmw_pkg::OP_UPDATE && hit) |=> (len_r <= $past(len_r)))
    else $error("loop erasure grew the path");
`endif

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for wall_follower_maze_walk_top
// A short table of directed start words runs first, under a handful of grid
// settings. Random phases follow, each with its own wall map, grid size, hand
// rule and step limit. Every accepted start word without a typed result
// word runs through a walk predictor that keeps its own copy of the
// registers. The predictor queues the loop-erased path it expects. Each
// result word is then checked field by field against the oldest queued cell.
// ----------------------------------------------------------------------------
module tb;

  localparam int ClkPeriod   = 12;
  localparam int LimitCycles = 8_000_000;
  localparam int HoldCycles  = 1500;
  localparam int TailCycles  = 40;
  localparam int StepW       = wfmw_pkg::StepW;
  localparam int CellW       = wfmw_pkg::CellW;
  localparam int MaxCells    = wfmw_pkg::MaxCells;
  localparam int MaxGrid     = wfmw_pkg::MaxGrid;

  // One result word as the block presents it.
  typedef struct packed {
    logic [2:0]        col;
    logic [2:0]        row;
    logic [StepW-1:0]  steps;
    wfmw_pkg::status_t status;
    logic              last;
  } path_word_t;

  // One row of the directed table. A nonzero grid_set loads that grid setting
  // first; typed rows carry their single result word, the rest go to the
  // predictor.
  typedef struct {
    int         grid_set;
    logic [2:0] col;
    logic [2:0] row;
    logic [1:0] head;
    bit         typed;
    path_word_t want;
  } start_row_t;

  typedef struct {
    logic [63:0]      walls;
    logic [3:0]       side;
    logic             left;
    logic [StepW-1:0] limit;
  } grid_setting_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  // Register copies used by the predictor.
  logic [63:0]      wall_bits;
  logic [3:0]       grid_cfg;
  logic             left_cfg;
  logic [StepW-1:0] limit_cfg;

  // Predictor's own path stores.
  logic [CellW-1:0] trail [MaxCells];
  logic [CellW-1:0] slot_of [MaxCells];
  int               trail_len;

  path_word_t    expected_path [$];
  start_row_t    start_table [$];
  grid_setting_t grid_sets [5];
  int            mismatches;
  int            send_idle;
  int            recv_idle;
  bit            hold_req;
  bit            hold_seen;
  int            hold_left;

  wall_follower_maze_walk_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock generation.
  always begin
    clk = 1'b0;
    #(ClkPeriod / 2);
    clk = 1'b1;
    #(ClkPeriod / 2);
  end

  // Grid side in use, with out-of-range settings clamped.
  function automatic int grid_side();
    if (grid_cfg < 2) return 2;
    if (grid_cfg > MaxGrid) return MaxGrid;
    return int'(grid_cfg);
  endfunction

  // Looks one cell ahead; the cell must be inside the grid and not a wall.
  function automatic bit step_open(int c, int r, logic [1:0] h, int n,
                                   output int nc, output int nr);
    nc = c;
    nr = r;
    case (h)
      wfmw_pkg::HeadUp:    nr = r - 1;
      wfmw_pkg::HeadRight: nc = c + 1;
      wfmw_pkg::HeadDown:  nr = r + 1;
      default:             nc = c - 1;
    endcase
    if (nc < 0 || nr < 0 || nc >= n || nr >= n) return 1'b0;
    return !wall_bits[nr * n + nc];
  endfunction

  // Extends the path, or cuts it back to an earlier visit of the same cell.
  function automatic void note_cell(int c, int r, int n);
    int cell_no;
    int pos;
    cell_no = (r * n + c) & 63;
    pos     = int'(slot_of[cell_no]);
    if (pos < trail_len && int'(trail[pos]) == cell_no) begin
      trail_len = pos + 1;
    end else if (trail_len < MaxCells) begin
      trail[trail_len] = CellW'(cell_no);
      slot_of[cell_no] = CellW'(trail_len);
      trail_len++;
    end
  endfunction

  // Walks the grid from one start word and queues the loop-erased path.
  function automatic void walk_path(logic [2:0] col, logic [2:0] row, logic [1:0] head);
    int                n;
    int                c;
    int                r;
    int                nc;
    int                nr;
    int                moves;
    int                tries;
    int                k;
    logic [1:0]        h;
    wfmw_pkg::status_t st;
    bit                moved;
    path_word_t        w;
    n = grid_side();
    w = '0;
    if (col >= n || row >= n) begin
      w.status = wfmw_pkg::StBadStart;
      w.last   = 1'b1;
      expected_path.push_back(w);
      return;
    end
    c         = col;
    r         = row;
    h         = head;
    moves     = 0;
    st        = wfmw_pkg::StGoal;
    trail_len = 0;
    note_cell(c, r, n);
    while (!(c == n - 1 && r == n - 1)) begin
      if (moves >= limit_cfg) begin
        st = wfmw_pkg::StLimit;
        break;
      end
      h     = left_cfg ? h - 2'd1 : h + 2'd1;
      moved = 1'b0;
      for (tries = 0; tries < 4; tries++) begin
        if (step_open(c, r, h, n, nc, nr)) begin
          moved = 1'b1;
          break;
        end
        h = left_cfg ? h + 2'd1 : h - 2'd1;
      end
      if (!moved) begin
        st = wfmw_pkg::StBoxed;
        break;
      end
      c     = nc;
      r     = nr;
      moves = (moves + 1) & 4095;
      note_cell(c, r, n);
    end
    for (k = 0; k < trail_len; k++) begin
      w.col    = 3'(int'(trail[k]) % n);
      w.row    = 3'(int'(trail[k]) / n);
      w.steps  = StepW'(moves);
      w.status = st;
      w.last   = (k + 1 == trail_len);
      expected_path.push_back(w);
    end
  endfunction

  // Single-word result whose value can be read off directly.
  function automatic path_word_t single_word(logic [2:0] col, logic [2:0] row,
                                             wfmw_pkg::status_t st);
    path_word_t w;
    w        = '0;
    w.col    = col;
    w.row    = row;
    w.status = st;
    w.last   = 1'b1;
    return w;
  endfunction

  task automatic add_row(int grid_set, logic [2:0] col, logic [2:0] row, logic [1:0] head,
                         bit typed, path_word_t want);
    start_row_t s;
    s.grid_set = grid_set;
    s.col      = col;
    s.row      = row;
    s.head     = head;
    s.typed    = typed;
    s.want     = want;
    start_table.push_back(s);
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 3'b000};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      wfmw_pkg::RegWallMap:   wall_bits = val;
      wfmw_pkg::RegGridSize:  grid_cfg  = val[3:0];
      wfmw_pkg::RegLeftHand:  left_cfg  = val[0];
      wfmw_pkg::RegStepLimit: limit_cfg = val[StepW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic load_grid(grid_setting_t g);
    reg_write(wfmw_pkg::RegWallMap, g.walls);
    reg_write(wfmw_pkg::RegGridSize, 64'(g.side));
    reg_write(wfmw_pkg::RegLeftHand, 64'(g.left));
    reg_write(wfmw_pkg::RegStepLimit, 64'(g.limit));
  endtask

  // Offers one start word, with random idle cycles ahead of it.
  task automatic send_start(logic [2:0] col, logic [2:0] row, logic [1:0] head,
                            bit typed, path_word_t want);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {head, row, col};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (typed) expected_path.push_back(want);
    else walk_path(col, row, head);
    @(negedge clk);
  endtask

  // Stops offering words and waits until every expected cell has come out.
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (expected_path.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        send_idle = 37;
        recv_idle = 73;
      end
      1: begin
        send_idle = 73;
        recv_idle = 37;
      end
      default: begin
        send_idle = 0;
        recv_idle = 0;
      end
    endcase
  endtask

  // Receiver: random stalls, plus a long hold-off each time one is requested.
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle);
    end
  end

  // Result checker: every accepted word against the oldest expected cell.
  always @(posedge clk) begin : check_words
    path_word_t got;
    path_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.col    = out_tdata[2:0];
      got.row    = out_tdata[5:3];
      got.steps  = out_tdata[17:6];
      got.status = out_tuser;
      got.last   = out_tlast;
      if (expected_path.size() == 0) begin
        $error("unexpected result word: cell_col %0d cell_row %0d walk_steps %0d status %0d",
               got.col, got.row, got.steps, got.status);
        mismatches++;
      end else begin
        want = expected_path.pop_front();
        if (got.col !== want.col) begin
          $error("cell_col mismatch: expected %0d, actual %0d", want.col, got.col);
          mismatches++;
        end
        if (got.row !== want.row) begin
          $error("cell_row mismatch: expected %0d, actual %0d", want.row, got.row);
          mismatches++;
        end
        if (got.steps !== want.steps) begin
          $error("walk_steps mismatch: expected %0d, actual %0d", want.steps, got.steps);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("last_cell mismatch: expected %0d, actual %0d", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    repeat (LimitCycles) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main sequence.
  initial begin : main_seq
    int            i;
    int            p;
    int            n;
    int            count;
    logic [2:0]    col;
    logic [2:0]    row;
    logic [63:0]   walls;
    grid_setting_t g;

    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    wall_bits   = '0;
    grid_cfg    = 4'd3;
    left_cfg    = 1'b0;
    limit_cfg   = StepW'(1024);
    trail_len   = 0;
    mismatches  = 0;
    hold_req    = 1'b0;
    hold_seen   = 1'b0;
    hold_left   = 0;
    for (i = 0; i < MaxCells; i++) begin
      trail[i]   = '0;
      slot_of[i] = '0;
    end
    set_idling(0);

    // Directed grid settings. Set 1 boxes in the cell at column 1, row 1 of a
    // 4x4 grid under the left-hand rule with a one-move limit. Set 2 walls
    // every cell of a clamped 2x2 grid with a zero limit. Set 3 is an open
    // 8x8 grid with the largest limit. Set 4 walls only the goal, so the walk
    // circles until the limit.
    grid_sets[1] = '{64'h0252, 4'd4, 1'b1, StepW'(1)};
    grid_sets[2] = '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, StepW'(0)};
    grid_sets[3] = '{64'h0, 4'd8, 1'b0, StepW'(4095)};
    grid_sets[4] = '{64'h8000_0000_0000_0000, 4'd15, 1'b1, StepW'(4095)};

    // Reset values: 3x3 open grid, right-hand rule.
    add_row(0, 3'd3, 3'd0, 2'd0, 1, single_word(3'd0, 3'd0, wfmw_pkg::StBadStart));
    add_row(0, 3'd0, 3'd7, 2'd1, 1, single_word(3'd0, 3'd0, wfmw_pkg::StBadStart));
    add_row(0, 3'd7, 3'd7, 2'd3, 1, single_word(3'd0, 3'd0, wfmw_pkg::StBadStart));
    add_row(0, 3'd2, 3'd2, 2'd2, 1, single_word(3'd2, 3'd2, wfmw_pkg::StGoal));
    add_row(0, 3'd0, 3'd0, 2'd0, 0, '0);
    add_row(0, 3'd0, 3'd0, 2'd1, 0, '0);
    add_row(0, 3'd1, 3'd2, 2'd2, 0, '0);
    add_row(0, 3'd2, 3'd0, 2'd3, 0, '0);
    // Boxed in, step limit and a start on a wall cell.
    add_row(1, 3'd1, 3'd1, 2'd0, 1, single_word(3'd1, 3'd1, wfmw_pkg::StBoxed));
    add_row(0, 3'd0, 3'd0, 2'd3, 1, single_word(3'd0, 3'd0, wfmw_pkg::StBoxed));
    add_row(0, 3'd3, 3'd0, 2'd0, 0, '0);
    add_row(0, 3'd1, 3'd0, 2'd2, 0, '0);
    add_row(0, 3'd3, 3'd3, 2'd1, 1, single_word(3'd3, 3'd3, wfmw_pkg::StGoal));
    add_row(0, 3'd4, 3'd0, 2'd1, 1, single_word(3'd0, 3'd0, wfmw_pkg::StBadStart));
    // Grid size below range and a zero step limit.
    add_row(2, 3'd0, 3'd0, 2'd0, 1, single_word(3'd0, 3'd0, wfmw_pkg::StLimit));
    add_row(0, 3'd1, 3'd1, 2'd3, 1, single_word(3'd1, 3'd1, wfmw_pkg::StGoal));
    add_row(0, 3'd2, 3'd1, 2'd2, 1, single_word(3'd0, 3'd0, wfmw_pkg::StBadStart));
    add_row(0, 3'd0, 3'd1, 2'd1, 1, single_word(3'd0, 3'd1, wfmw_pkg::StLimit));
    // Largest grid, open.
    add_row(3, 3'd0, 3'd0, 2'd0, 0, '0);
    add_row(0, 3'd7, 3'd0, 2'd2, 0, '0);
    add_row(0, 3'd0, 3'd7, 2'd3, 0, '0);
    add_row(0, 3'd7, 3'd7, 2'd0, 1, single_word(3'd7, 3'd7, wfmw_pkg::StGoal));
    // Grid size above range with the goal walled off.
    add_row(4, 3'd0, 3'd0, 2'd1, 0, '0);
    add_row(0, 3'd7, 3'd7, 2'd2, 1, single_word(3'd7, 3'd7, wfmw_pkg::StGoal));

    // Reset.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed table.
    foreach (start_table[i]) begin
      if (start_table[i].grid_set != 0) begin
        wait_drained();
        load_grid(grid_sets[start_table[i].grid_set]);
      end
      send_start(start_table[i].col, start_table[i].row, start_table[i].head,
                 start_table[i].typed, start_table[i].want);
    end

    // Random phases, each under a fresh grid setting.
    for (p = 0; p < 8; p++) begin
      wait_drained();
      set_idling(p < 3 ? 0 : (p < 6 ? 1 : 2));
      g.side = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(2, 8));
      walls  = {$urandom, $urandom} & {$urandom, $urandom};
      case (p % 3)
        0: walls = walls | ({$urandom, $urandom} & {$urandom, $urandom});
        1: walls = walls & {$urandom, $urandom};
        default: ;
      endcase
      g.left = 1'($urandom_range(1));
      if (p == 7) g.limit = StepW'(4095);
      else if (p == 2) g.limit = StepW'(1);
      else g.limit = StepW'($urandom_range(1, 250));
      count = (p == 7) ? 6 : 28;
      grid_cfg = g.side;
      n = grid_side();
      // Keep the goal open in most phases so that walks can finish.
      if (p % 4 != 3) walls[n * n - 1] = 1'b0;
      g.walls = walls;
      load_grid(g);

      // Long output hold-off while start words keep coming.
      if (p == 1) hold_req = ~hold_req;

      for (i = 0; i < count; i++) begin
        if (p == 4 && i == 14) wait_drained();
        if ($urandom_range(6) == 0) begin
          col = 3'($urandom_range(7));
          row = 3'($urandom_range(7));
        end else begin
          col = 3'($urandom_range(n - 1));
          row = 3'($urandom_range(n - 1));
        end
        send_start(col, row, 2'($urandom_range(3)), 0, '0);
      end
    end

    // Drain and watch for stray words.
    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
